// ===== src/ptd_pkg.sv =====
// ---------------------------------------------------------------------------
// Periodic tick dispatch package
// Shared types, request and status codes, default sizes and a width helper.
// ---------------------------------------------------------------------------
package ptd_pkg;

	localparam int DEF_TIMER_COUNT     = 9;
	localparam int DEF_SLOTS_PER_TIMER = 8;
	localparam int DEF_QUEUE_DEPTH     = 32;
	localparam int DEF_ID_BITS         = 8;

	// Request codes.
	localparam logic [2:0] FUNC_ATTACH = 3'd0;
	localparam logic [2:0] FUNC_DETACH = 3'd1;
	localparam logic [2:0] FUNC_FIRE   = 3'd2;
	localparam logic [2:0] FUNC_POP    = 3'd3;
	localparam logic [2:0] FUNC_FLUSH  = 3'd4;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NO_TIMER = 3'd2;
	localparam logic [2:0] ST_NO_SLOT  = 3'd3;
	localparam logic [2:0] ST_BAD      = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  observer_id;
		logic [31:0] interval;
		logic [3:0]  timer_number;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  timer_index;
		logic        start_timer;
		logic [31:0] period;
		logic [3:0]  removed_count;
		logic [3:0]  enqueued_count;
		logic [7:0]  popped_id;
		logic [5:0]  queue_level;
	} rsp_item_t;

	// Index width for n entries, never below one bit.
	function automatic int cbits(input int n);
		int r;
		r = $clog2(n);
		return (r < 1) ? 1 : r;
	endfunction

endpackage

// ===== src/ptd_chan_if.sv =====
// ---------------------------------------------------------------------------
// Valid/ready channel
// Carries one word per handshake: valid, ready and a payload of type T.
// ---------------------------------------------------------------------------
interface ptd_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/periodic_tick_dispatch_table.sv =====
// ---------------------------------------------------------------------------
// Periodic tick dispatch table
// Timer table with subscriber slots and a dispatch ring, run by a sequencer.
// ---------------------------------------------------------------------------
// Usage: requests arrive as words on req (attach, detach, fire, pop, flush)
// and every request yields exactly one word on rsp. Both channels move a word
// when valid and ready are high at a rising edge of clk.
// The block takes one request at a time: req.ready is high only while the
// sequencer is idle. How long a request takes is set by the scans over
// the slot memory, which has one read port:
//   attach  scans the timer table, then the slots of the chosen timer,
//           or ends after the timer scan when no timer can be claimed,
//   detach  scans every slot of every timer,
//   fire    scans the slots of its timer; pop, flush and rejects scan none.
// Results sit in an output register; a new request may be accepted while
// the previous result still waits there. If the receiver stalls, the
// finished result of the next request is held in the sequencer until the
// output register frees up, so nothing is lost or repeated.
// After reset the slot memory is cleared one entry per cycle, every slot in
// turn; req.ready stays low during that pass. Timer periods and the ring
// pointers reset at once.
// ---------------------------------------------------------------------------
module periodic_tick_dispatch_table
	import ptd_pkg::*;
#(
	parameter int TIMER_COUNT     = DEF_TIMER_COUNT,
	parameter int SLOTS_PER_TIMER = DEF_SLOTS_PER_TIMER,
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
	parameter int ID_BITS         = DEF_ID_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	ptd_chan_if.sink   req,
	ptd_chan_if.source rsp
);

	localparam int NSLOT = TIMER_COUNT * SLOTS_PER_TIMER;
	localparam int TW    = cbits(TIMER_COUNT);
	localparam int TCW   = $clog2(TIMER_COUNT + 1);
	localparam int SW    = cbits(SLOTS_PER_TIMER);
	localparam int AW    = cbits(NSLOT);
	localparam int NCW   = $clog2(NSLOT + 1);
	localparam int QW    = cbits(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_TSCAN = 3'd2;
	localparam logic [2:0] S_BASE  = 3'd3;
	localparam logic [2:0] S_SSCAN = 3'd4;
	localparam logic [2:0] S_POP   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [2:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic [31:0]        per_q;

	// Timer table; a period of zero marks a free timer.
	logic [31:0]        period_q [TIMER_COUNT];

	// Timer scan.
	logic [TCW-1:0]     tcnt_q;
	logic               match_found_q, free_found_q;
	logic [TW-1:0]      match_q, free_q, sel_t_q;

	// Slot scan.
	logic [AW-1:0]      base_q;
	logic [NCW-1:0]     cnt_q, len_q, n_q;
	logic               valid_s1;
	logic [AW-1:0]      addr_s1;
	logic [SW-1:0]      pos_s1;
	logic               dup_q, empty_found_q, ovf_q;
	logic [SW-1:0]      empty_q;

	// Slot memory.
	logic [ID_BITS-1:0] slot_mem [NSLOT];
	logic [ID_BITS-1:0] slot_rd_s1;
	logic               slot_we;
	logic [AW-1:0]      slot_wa, slot_ra, fin_addr;
	logic [ID_BITS-1:0] slot_wd;

	// Dispatch ring.
	logic [ID_BITS-1:0] q_mem [QUEUE_DEPTH];
	logic [ID_BITS-1:0] q_rd_s1;
	logic [QW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic               q_full, q_we;

	// Result under construction and output register.
	rsp_item_t          res_q;
	rsp_item_t          rsp_data_q;
	logic               rsp_valid_q;
	rsp_item_t          res_init, res_done;
	logic [2:0]         acc_status;

	logic               accept, issue, scan_end, out_free, tscan_hit;
	logic [ID_BITS-1:0] req_id;

	assign accept   = req.valid && req.ready;
	assign req_id   = ID_BITS'(req.data.observer_id);
	assign issue    = (state_q == S_SSCAN) && (cnt_q < len_q);
	assign scan_end = (state_q == S_SSCAN) && (cnt_q == len_q) && !valid_s1;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign q_full   = (count_q == CW'(QUEUE_DEPTH));
	assign slot_ra  = AW'(32'(base_q) + 32'(cnt_q));
	assign fin_addr = AW'(32'(base_q) + 32'(empty_q));
	assign tscan_hit = (state_q == S_TSCAN) && (tcnt_q < TCW'(TIMER_COUNT));

	// A fired subscriber goes into the ring only while there is room.
	assign q_we = (state_q == S_SSCAN) && (op_q == FUNC_FIRE) && valid_s1
		&& (slot_rd_s1 != '0) && !q_full;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Status known at acceptance; later states refine it.
	always_comb begin
		acc_status = ST_BAD;
		case (req.data.func) inside
			FUNC_ATTACH, FUNC_DETACH: begin
				if (req_id != '0 && (req.data.func == FUNC_DETACH
					|| req.data.interval != '0)) begin
					acc_status = ST_OK;
				end
			end
			FUNC_FIRE: begin
				if (int'(req.data.timer_number) < TIMER_COUNT) begin
					acc_status = ST_OK;
				end
			end
			FUNC_POP: begin
				acc_status = (count_q == '0) ? ST_EMPTY : ST_OK;
			end
			FUNC_FLUSH: begin
				acc_status = ST_OK;
			end
			default: begin
			end
		endcase
		res_init        = '0;
		res_init.status = acc_status;
	end

	// The ring level is reported as it stands when the result is handed over.
	always_comb begin
		res_done             = res_q;
		res_done.queue_level = 6'(count_q);
	end

	// Slot memory write: reset clearing pass, detach clearing matches, and
	// the final write of a successful attach.
	always_comb begin
		slot_we = 1'b0;
		slot_wa = addr_s1;
		slot_wd = '0;
		if (state_q == S_CLEAR) begin
			slot_we = 1'b1;
			slot_wa = cnt_q[AW-1:0];
		end else if (state_q == S_SSCAN) begin
			if (op_q == FUNC_DETACH && valid_s1 && slot_rd_s1 == id_q) begin
				slot_we = 1'b1;
			end else if (op_q == FUNC_ATTACH && scan_end && !dup_q && empty_found_q) begin
				slot_we = 1'b1;
				slot_wa = fin_addr;
				slot_wd = id_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		slot_rd_s1 <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[head_q] <= slot_rd_s1;
		end
		q_rd_s1 <= q_mem[tail_q];
	end

	// Read pipeline bookkeeping for the slot scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= slot_ra;
		pos_s1  <= SW'(cnt_q);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_data_q <= res_done;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cnt_q         <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				period_q[i] <= '0;
			end
			op_q          <= FUNC_ATTACH;
			tcnt_q        <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			dup_q         <= 1'b0;
			empty_found_q <= 1'b0;
			ovf_q         <= 1'b0;
			n_q           <= '0;
			len_q         <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == NCW'(NSLOT - 1)) begin
						state_q <= S_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						op_q          <= req.data.func;
						sel_t_q       <= TW'(req.data.timer_number);
						tcnt_q        <= '0;
						cnt_q         <= '0;
						n_q           <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						dup_q         <= 1'b0;
						empty_found_q <= 1'b0;
						ovf_q         <= 1'b0;
						case (req.data.func)
							FUNC_ATTACH: begin
								if (req_id != '0 && req.data.interval != '0) begin
									state_q <= S_TSCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
							FUNC_DETACH: begin
								if (req_id != '0) begin
									len_q   <= NCW'(NSLOT);
									state_q <= S_SSCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
							FUNC_FIRE: begin
								if (int'(req.data.timer_number) < TIMER_COUNT) begin
									state_q <= S_BASE;
								end else begin
									state_q <= S_DONE;
								end
							end
							FUNC_POP: begin
								if (count_q != '0) begin
									state_q <= S_POP;
								end else begin
									state_q <= S_DONE;
								end
							end
							FUNC_FLUSH: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_TSCAN: begin
					if (tscan_hit) begin
						if (period_q[tcnt_q[TW-1:0]] == per_q && !match_found_q) begin
							match_found_q <= 1'b1;
							match_q       <= TW'(tcnt_q);
						end
						if (period_q[tcnt_q[TW-1:0]] == '0 && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q       <= TW'(tcnt_q);
						end
						tcnt_q <= tcnt_q + 1'b1;
					end else if (match_found_q) begin
						sel_t_q <= match_q;
						state_q <= S_BASE;
					end else if (free_found_q) begin
						sel_t_q <= free_q;
						state_q <= S_BASE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_BASE: begin
					len_q   <= NCW'(SLOTS_PER_TIMER);
					state_q <= S_SSCAN;
				end
				S_SSCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (valid_s1) begin
						unique case (op_q)
							FUNC_ATTACH: begin
								if (slot_rd_s1 == id_q) begin
									dup_q <= 1'b1;
								end
								if (slot_rd_s1 == '0 && !empty_found_q) begin
									empty_found_q <= 1'b1;
									empty_q       <= pos_s1;
								end
							end
							FUNC_DETACH: begin
								if (slot_rd_s1 == id_q) begin
									n_q <= n_q + 1'b1;
								end
							end
							default: begin
								if (slot_rd_s1 != '0) begin
									if (q_full) begin
										ovf_q <= 1'b1;
									end else begin
										head_q  <= (head_q == QW'(QUEUE_DEPTH - 1))
											? '0 : head_q + 1'b1;
										count_q <= count_q + 1'b1;
										n_q     <= n_q + 1'b1;
									end
								end
							end
						endcase
					end
					if (scan_end) begin
						state_q <= S_DONE;
						if (op_q == FUNC_ATTACH && !dup_q && empty_found_q) begin
							period_q[sel_t_q] <= per_q;
						end
					end
				end
				S_POP: begin
					tail_q  <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and result fields; no reset needed. A detach scan
	// starts at slot zero, other scans get their base in S_BASE.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= req_id;
			per_q  <= req.data.interval;
			base_q <= '0;
			res_q  <= res_init;
		end else if (state_q == S_TSCAN && !tscan_hit && !match_found_q
			&& !free_found_q) begin
			res_q.status <= ST_NO_TIMER;
		end else if (state_q == S_BASE) begin
			base_q <= AW'(32'(sel_t_q) * SLOTS_PER_TIMER);
		end else if (state_q == S_POP) begin
			res_q.popped_id <= 8'(q_rd_s1);
		end else if (scan_end) begin
			if (op_q == FUNC_ATTACH) begin
				if (dup_q) begin
					res_q.status <= ST_DUP;
				end else if (!empty_found_q) begin
					res_q.status <= ST_NO_SLOT;
				end else begin
					res_q.timer_index <= 4'(sel_t_q);
					res_q.start_timer <= 1'b1;
					res_q.period      <= per_q;
				end
			end else if (op_q == FUNC_DETACH) begin
				res_q.removed_count <= 4'(n_q);
			end else begin
				res_q.enqueued_count <= 4'(n_q);
				res_q.status         <= ovf_q ? ST_OVERFLOW : ST_OK;
			end
		end
	end

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("dispatch ring count above its depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty ring with head and tail apart");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == S_SSCAN))
		else $error("slot read data outside a slot scan");

	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.start_timer) |-> (rsp.data.status == ST_OK
			&& rsp.data.period != '0))
		else $error("timer start without a successful attach");

endmodule

// ===== verif/periodic_tick_dispatch_table_tb.sv =====
// ---------------------------------------------------------------------------
// Periodic tick dispatch table testbench
// Sends attach, detach, fire, pop, flush and unused request words through
// the valid/ready request channel, keeps its own copy of the timer table and
// the dispatch ring, and compares every response word field by field.
// ---------------------------------------------------------------------------
module periodic_tick_dispatch_table_tb;
	import ptd_pkg::*;

	localparam int TIMERS = DEF_TIMER_COUNT;
	localparam int SLOTS  = DEF_SLOTS_PER_TIMER;
	localparam int RING   = DEF_QUEUE_DEPTH;

	// Request codes the block does not define. They must come back as bad requests.
	localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
	localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

	localparam int RANDOM_WORDS = 850;
	// The slowest request is a detach, which scans every slot, so this much
	// quiet time at the end is enough to catch any stray response word.
	localparam int TAIL_CYCLES  = 100;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_LIMIT = 10;

	// Receiver behavior. The mode is drawn anew at random intervals, so that
	// stalls land on every phase of the sequencer and some stretches run
	// with no stall at all.
	typedef enum int {RX_FREE, RX_CHOPPY, RX_STARVED} rx_mode_t;

	// A backlog entry is either a request word or a hold, which keeps the
	// sender quiet until every outstanding response has come back.
	typedef struct {
		bit        hold;
		req_item_t word;
	} backlog_entry_t;

	logic clk;
	logic arst_n;

	ptd_chan_if #(.T(req_item_t)) req_ch ();
	ptd_chan_if #(.T(rsp_item_t)) rsp_ch ();

	periodic_tick_dispatch_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the block's state.
	logic [31:0] tmr_period [TIMERS];
	logic [7:0]  slot_id    [TIMERS][SLOTS];
	logic [7:0]  ring_word  [RING];
	int          ring_head;
	int          ring_tail;
	int          ring_count;

	backlog_entry_t req_backlog [$];
	rsp_item_t      pending_rsp [$];

	int       words_built = 0;
	int       words_sent = 0;
	int       results_checked = 0;
	int       fail_count = 0;
	int       status_seen [8];
	int       cycle_count;
	logic     req_taken;
	int       burst_left = 4;
	int       gap_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_mode_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Prediction
	// -----------------------------------------------------------------------

	function automatic void clear_dispatch_state();
		for (int t = 0; t < TIMERS; t++) begin
			tmr_period[t] = '0;
			for (int s = 0; s < SLOTS; s++) slot_id[t][s] = '0;
		end
		ring_head  = 0;
		ring_tail  = 0;
		ring_count = 0;
	endfunction

	// Applies one accepted request word to the shadow state and returns the
	// response word the block owes for it.
	function automatic rsp_item_t predict_dispatch_rsp(input req_item_t w);
		rsp_item_t r;
		int        hit;
		int        free_slot;
		int        n;
		bit        dup;
		r = '0;
		case (w.func)
			FUNC_ATTACH: begin
				if (w.observer_id == '0 || w.interval == '0) begin
					r.status = ST_BAD;
				end else begin
					// A subscriber may sit on several timers, but only once per period.
					dup = 1'b0;
					for (int t = 0; t < TIMERS; t++)
						if (tmr_period[t] == w.interval)
							for (int s = 0; s < SLOTS; s++)
								if (slot_id[t][s] == w.observer_id) dup = 1'b1;
					hit = -1;
					for (int t = 0; t < TIMERS; t++)
						if (hit < 0 && tmr_period[t] == w.interval) hit = t;
					if (hit < 0)
						for (int t = 0; t < TIMERS; t++)
							if (hit < 0 && tmr_period[t] == '0) hit = t;
					free_slot = -1;
					if (hit >= 0)
						for (int s = 0; s < SLOTS; s++)
							if (free_slot < 0 && slot_id[hit][s] == '0) free_slot = s;
					if (dup) begin
						r.status = ST_DUP;
					end else if (hit < 0) begin
						r.status = ST_NO_TIMER;
					end else if (free_slot < 0) begin
						r.status = ST_NO_SLOT;
					end else begin
						tmr_period[hit]         = w.interval;
						slot_id[hit][free_slot] = w.observer_id;
						r.status      = ST_OK;
						r.timer_index = hit[3:0];
						r.start_timer = 1'b1;
						r.period      = w.interval;
					end
				end
			end
			FUNC_DETACH: begin
				if (w.observer_id == '0) begin
					r.status = ST_BAD;
				end else begin
					// Periods stay claimed even when every slot of a timer empties.
					n = 0;
					for (int t = 0; t < TIMERS; t++)
						for (int s = 0; s < SLOTS; s++)
							if (slot_id[t][s] == w.observer_id) begin
								slot_id[t][s] = '0;
								n++;
							end
					r.status        = ST_OK;
					r.removed_count = n[3:0];
				end
			end
			FUNC_FIRE: begin
				if (w.timer_number >= TIMERS) begin
					r.status = ST_BAD;
				end else begin
					// Entries that do not fit are dropped; the ring is never overwritten.
					n        = 0;
					r.status = ST_OK;
					for (int s = 0; s < SLOTS; s++)
						if (slot_id[w.timer_number][s] != '0) begin
							if (ring_count >= RING) begin
								r.status = ST_OVERFLOW;
							end else begin
								ring_word[ring_head] = slot_id[w.timer_number][s];
								ring_head = (ring_head + 1) % RING;
								ring_count++;
								n++;
							end
						end
					r.enqueued_count = n[3:0];
				end
			end
			FUNC_POP: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status    = ST_OK;
					r.popped_id = ring_word[ring_tail];
					ring_tail   = (ring_tail + 1) % RING;
					ring_count--;
				end
			end
			FUNC_FLUSH: begin
				ring_head  = 0;
				ring_tail  = 0;
				ring_count = 0;
				r.status   = ST_OK;
			end
			default: begin
				r.status = ST_BAD;
			end
		endcase
		r.queue_level = ring_count[5:0];
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Checking
	// -----------------------------------------------------------------------

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
	endtask

	function automatic string rsp_text(input rsp_item_t r);
		return $sformatf("st=%0d tmr=%0d start=%0d per=%h rem=%0d enq=%0d pop=%0d lvl=%0d",
			r.status, r.timer_index, r.start_timer, r.period, r.removed_count,
			r.enqueued_count, r.popped_id, r.queue_level);
	endfunction

	task automatic check_rsp(input rsp_item_t got);
		rsp_item_t want;
		string     diffs;
		if (pending_rsp.size() == 0) begin
			note_failure($sformatf("response word with nothing outstanding: %s", rsp_text(got)));
			return;
		end
		want = pending_rsp.pop_front();
		results_checked++;
		status_seen[want.status]++;
		diffs = "";
		if (got.status !== want.status) diffs = {diffs, " status"};
		if (got.timer_index !== want.timer_index) diffs = {diffs, " timer_index"};
		if (got.start_timer !== want.start_timer) diffs = {diffs, " start_timer"};
		if (got.period !== want.period) diffs = {diffs, " period"};
		if (got.removed_count !== want.removed_count) diffs = {diffs, " removed_count"};
		if (got.enqueued_count !== want.enqueued_count) diffs = {diffs, " enqueued_count"};
		if (got.popped_id !== want.popped_id) diffs = {diffs, " popped_id"};
		if (got.queue_level !== want.queue_level) diffs = {diffs, " queue_level"};
		if (diffs != "")
			note_failure($sformatf("response %0d wrong in%s\n  expected %s\n  actual   %s",
				results_checked, diffs, rsp_text(want), rsp_text(got)));
	endtask

	// Both channels are sampled at the rising edge. The response is checked
	// before the new request is predicted; a response can never belong to a
	// request taken at the same edge, so the order only keeps things tidy.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) check_rsp(rsp_ch.data);
			if (req_ch.valid && req_ch.ready) begin
				pending_rsp.push_back(predict_dispatch_rsp(req_ch.data));
				words_sent++;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sender: drives at the falling edge, in bursts with random gaps between.
	// A word that is up stays up, unchanged, until the edge that takes it.
	// -----------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (req_backlog[0].hold) begin
				// Hold until the block has answered everything it was given.
				req_ch.valid <= 1'b0;
				if (pending_rsp.size() == 0) req_backlog.delete(0);
			end else begin
				req_ch.data  <= req_backlog[0].word;
				req_ch.valid <= 1'b1;
				req_backlog.delete(0);
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					case ($urandom_range(0, 5))
						0, 1: gap_left <= 0;
						5: gap_left <= $urandom_range(20, 40);
						default: gap_left <= $urandom_range(1, 8);
					endcase
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Receiver: ready changes at the falling edge following its own pattern.
	// -----------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= rx_mode_t'($urandom_range(0, 2));
			rx_mode_left <= $urandom_range(10, 80);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_FREE: rsp_ch.ready <= 1'b1;
			RX_CHOPPY: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------

	task automatic push_word(input logic [2:0] func, input logic [7:0] id,
			input logic [31:0] interval, input logic [3:0] tn);
		backlog_entry_t e;
		e.hold              = 1'b0;
		e.word.func         = func;
		e.word.observer_id  = id;
		e.word.interval     = interval;
		e.word.timer_number = tn;
		req_backlog.push_back(e);
		words_built++;
	endtask

	task automatic push_hold();
		backlog_entry_t e;
		e.hold = 1'b1;
		e.word = '0;
		req_backlog.push_back(e);
	endtask

	// A short list of periods, so that attaches keep meeting timers that are
	// already claimed. Together they are enough to claim every timer.
	function automatic logic [31:0] pool_period(input int k);
		case (k)
			0: return 32'hFFFF_FFFF;
			1: return 32'd1;
			2: return 32'd10;
			3: return 32'd250;
			4: return 32'd1000;
			5: return 32'h0001_0000;
			6: return 32'h8000_0000;
			7: return 32'h00FF_00FF;
			default: return 32'h5555_AAAA;
		endcase
	endfunction

	// Mostly a small crowd of subscribers, so that duplicates, full timers
	// and multi-timer detaches come up often.
	function automatic logic [7:0] pick_id();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80) return 8'($urandom_range(1, 12));
		if (p < 92) return 8'($urandom_range(0, 255));
		if (p < 96) return 8'hFF;
		return 8'h00;
	endfunction

	function automatic logic [31:0] pick_interval();
		int p;
		p = $urandom_range(0, 99);
		if (p < 4) return '0;
		if (p < 8) return $urandom;
		return pool_period($urandom_range(0, TIMERS - 1));
	endfunction

	function automatic logic [3:0] pick_timer();
		if ($urandom_range(0, 99) < 88) return 4'($urandom_range(0, TIMERS - 1));
		return 4'($urandom_range(TIMERS, 15));
	endfunction

	task automatic build_directed();
		// Bad attaches: zero id, then zero period.
		push_word(FUNC_ATTACH, 8'h00, 32'd7, 4'd0);
		push_word(FUNC_ATTACH, 8'h01, 32'd0, 4'd15);
		// Largest id and period claim the first timer; the same pair again is a duplicate.
		push_word(FUNC_ATTACH, 8'hFF, 32'hFFFF_FFFF, 4'd0);
		push_word(FUNC_ATTACH, 8'hFF, 32'hFFFF_FFFF, 4'd15);
		// Fill the remaining slots of that timer, then one more finds no slot.
		for (int k = 1; k < SLOTS; k++) push_word(FUNC_ATTACH, k[7:0], 32'hFFFF_FFFF, 4'd0);
		push_word(FUNC_ATTACH, 8'h80, 32'hFFFF_FFFF, 4'd0);
		// Pop from an empty ring.
		push_word(FUNC_POP, 8'hFF, 32'hFFFF_FFFF, 4'd15);
		// Four fires of a full timer fill the ring exactly; the fifth overflows.
		for (int k = 0; k < 5; k++) push_word(FUNC_FIRE, 8'h00, 32'd0, 4'd0);
		// Fire of timer numbers past the table.
		push_word(FUNC_FIRE, 8'h00, 32'd0, 4'(TIMERS));
		push_word(FUNC_FIRE, 8'h00, 32'd0, 4'd15);
		push_word(FUNC_POP, 8'h00, 32'd0, 4'd0);
		// Request codes outside the defined set.
		push_word(FUNC_RSVD_FIRST, 8'h01, 32'd1, 4'd1);
		push_word(FUNC_RSVD_FIRST + 3'd1, 8'h01, 32'd1, 4'd1);
		push_word(FUNC_RSVD_LAST, 8'h01, 32'd1, 4'd1);
		// Bad detach, then a real one, then flush the ring.
		push_word(FUNC_DETACH, 8'h00, 32'hFFFF_FFFF, 4'd0);
		push_word(FUNC_DETACH, 8'hFF, 32'd0, 4'd0);
		push_word(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 4'd15);
	endtask

	task automatic build_random();
		int          pick;
		bit          held;
		logic [7:0]  id;
		held = 1'b0;
		while (words_built < RANDOM_WORDS) begin
			if (!held && words_built > RANDOM_WORDS / 2) begin
				push_hold();
				held = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				// Spread one subscriber over every pooled period, fire a few
				// timers, then detach it from all of them at once.
				id = 8'($urandom_range(1, 12));
				for (int k = 0; k < TIMERS; k++)
					push_word(FUNC_ATTACH, id, pool_period(k), 4'($urandom_range(0, 15)));
				push_word(FUNC_FIRE, 8'($urandom_range(0, 255)), $urandom, pick_timer());
				push_word(FUNC_FIRE, 8'($urandom_range(0, 255)), $urandom, pick_timer());
				push_word(FUNC_DETACH, id, $urandom, 4'($urandom_range(0, 15)));
			end else if (pick < 37) begin
				push_word(FUNC_ATTACH, pick_id(), pick_interval(), 4'($urandom_range(0, 15)));
			end else if (pick < 47) begin
				push_word(FUNC_DETACH, pick_id(), $urandom, 4'($urandom_range(0, 15)));
			end else if (pick < 67) begin
				push_word(FUNC_FIRE, 8'($urandom_range(0, 255)), $urandom, pick_timer());
			end else if (pick < 93) begin
				push_word(FUNC_POP, 8'($urandom_range(0, 255)), $urandom,
					4'($urandom_range(0, 15)));
			end else if (pick < 97) begin
				push_word(FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom,
					4'($urandom_range(0, 15)));
			end else begin
				push_word(3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST)),
					8'($urandom_range(0, 255)), $urandom, 4'($urandom_range(0, 15)));
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Watchdog
	// -----------------------------------------------------------------------
	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$display("ERROR: no finish after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		for (int k = 0; k < 8; k++) status_seen[k] = 0;
		clear_dispatch_state();

		// The directed words come first, then a full drain, then the random mix.
		build_directed();
		push_hold();
		build_random();

		// The block clears its slot memory after reset and holds req.ready low
		// meanwhile, so the sender simply waits on the handshake.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || req_ch.valid) @(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_rsp.size() != 0)
			note_failure($sformatf("%0d responses never arrived", pending_rsp.size()));
		$display("Sent %0d request words and checked %0d responses under bursty sending, %s",
			words_sent, results_checked, "receiver stalls and drain pauses.");
		$display("Statuses: ok %0d, dup %0d, no timer %0d, no slot %0d, bad %0d, %s %0d, empty %0d",
			status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NO_TIMER],
			status_seen[ST_NO_SLOT], status_seen[ST_BAD], "overflow",
			status_seen[ST_OVERFLOW], status_seen[ST_EMPTY]);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== periodic_tick_dispatch_table.f =====
src/ptd_pkg.sv
src/ptd_chan_if.sv
src/periodic_tick_dispatch_table.sv
verif/periodic_tick_dispatch_table_tb.sv
